// File: src/modular_exponentiation_macros.svh
// ---------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MEXP_ASSERT(label, prop, msg)
`define MEXP_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// File: src/mexp_pkg.sv
// ---------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation block
// ---------------------------------------------------------------------------
package mexp_pkg;

  localparam int DATA_W            = 64;
  localparam int OPERAND_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam logic [DATA_W-1:0] LOW_BIT_ONE = 64'h1;

  typedef struct packed {
    logic [DATA_W-1:0] base_value;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
    logic              zero_mod;
  } mexp_req_t;

  typedef struct packed {
    logic push;
  } mexp_qctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_DONE
  } mexp_state_t;

endpackage

// File: src/modular_exponentiation.sv
// ---------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus, right-to-left square-and-multiply
// ---------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with base, exponent and modulus; each
// request gives one result on out_valid/out_stall. Operand bits above
// OPERAND_WIDTH (W) are ignored. A zero modulus returns 0 with
// out_zero_modulus_error set, skipping the reduce and multiply steps.
// The base is first reduced by a shift-subtract loop, then W exponent steps
// each run two bit-serial modular multipliers (square and multiply side by
// side).
// The engine takes a new request only after finishing the last. A front
// register and a two-entry queue take up to three further requests while
// one is being worked on; the result register lets the next request start
// while a result waits.
// A stalled result holds its value; the engine waits in its done state.
// Reset (rst_n low, synchronous) empties queue, engine and result register.
// ---------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_base_value,
  input  logic [DATA_W-1:0] in_exponent,
  input  logic [DATA_W-1:0] in_modulus,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_power_result,
  output logic              out_zero_modulus_error
);

  mexp_qctl_t q_ctl;
  mexp_req_t  q_wr, q_rd;
  logic       q_full, q_empty, q_pop;

  mexp_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_base_value(in_base_value), .in_exponent(in_exponent), .in_modulus(in_modulus),
    .q_full(q_full), .q_ctl(q_ctl), .q_data(q_wr)
  );

  mexp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .ctl(q_ctl), .wr_data(q_wr), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rd_data(q_rd)
  );

  mexp_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_data(q_rd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_power_result(out_power_result),
    .out_zero_modulus_error(out_zero_modulus_error)
  );

endmodule

// File: src/mexp_front.sv
// ---------------------------------------------------------------------------
// mexp_front
// accepts requests, masks operands and flags a zero modulus
// ---------------------------------------------------------------------------
module mexp_front import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_base_value,
  input  logic [DATA_W-1:0] in_exponent,
  input  logic [DATA_W-1:0] in_modulus,
  input  logic              q_full,
  output mexp_qctl_t        q_ctl,
  output mexp_req_t         q_data
);

  localparam logic [DATA_W-1:0] MASK = {DATA_W{1'b1}} >> (DATA_W - OPERAND_WIDTH);

  logic      valid_r, valid_nxt;
  mexp_req_t req_r;
  logic      accept;

  assign in_stall    = valid_r & q_full;
  assign accept      = in_valid & ~in_stall;
  assign valid_nxt   = accept | (valid_r & q_full);
  assign q_ctl.push  = valid_r & ~q_full;
  assign q_data      = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.base_value <= in_base_value & MASK;
      req_r.exponent   <= in_exponent & MASK;
      req_r.modulus    <= in_modulus & MASK;
      req_r.zero_mod   <= ((in_modulus & MASK) == '0);
    end
  end

endmodule

// File: src/mexp_queue.sv
// ---------------------------------------------------------------------------
// mexp_queue
// two-entry request queue between front and back
// ---------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"
module mexp_queue import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mexp_qctl_t ctl,
  input  mexp_req_t  wr_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output mexp_req_t  rd_data
);

  mexp_req_t  mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'(QUEUE_DEPTH));
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!ctl.push && pop && !empty) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `MEXP_ASSERT(a_count_bound, count_r <= 2'(QUEUE_DEPTH), "queue count overflow")
  `MEXP_ASSERT_IMP(a_no_push_full, full, !ctl.push, "push into full queue")
  `MEXP_ASSERT_IMP(a_ptr_match, empty, wr_ptr_r == rd_ptr_r, "pointers disagree when empty")

endmodule

// File: src/mexp_back.sv
// ---------------------------------------------------------------------------
// mexp_back
// reduces the base, runs square-and-multiply with two bit-serial
// modular multipliers and holds the result register
// ---------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"
module mexp_back import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mexp_req_t         q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_power_result,
  output logic              out_zero_modulus_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [W-1:0]  ONE  = LOW_BIT_ONE[W-1:0];
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  mexp_state_t   state_r, state_nxt;
  logic [W-1:0]  m_r, m_nxt, b_r, b_nxt, e_r, e_nxt, rr_r, rr_nxt;
  logic [W-1:0]  acc_r, acc_nxt, sq_r, sq_nxt, pa_r, pa_nxt, ps_r, ps_nxt;
  logic [CW-1:0] bit_r, bit_nxt, exp_r, exp_nxt;
  logic          err_r, err_nxt;
  logic          ovalid_r, ovalid_nxt, oerr_r;
  logic [W-1:0]  ores_r;
  logic          out_load;
  logic [W:0]    red_t;
  logic [W-1:0]  pa2, ps2, pa_step, ps_step;

  assign out_valid              = ovalid_r;
  assign out_power_result       = DATA_W'(ores_r);
  assign out_zero_modulus_error = oerr_r;

  always_comb begin
    red_t   = {rr_r, b_r[W-1]};
    pa2     = add_mod(pa_r, pa_r, m_r);
    ps2     = add_mod(ps_r, ps_r, m_r);
    pa_step = sq_r[bit_r] ? add_mod(pa2, acc_r, m_r) : pa2;
    ps_step = sq_r[bit_r] ? add_mod(ps2, sq_r, m_r) : ps2;
  end

  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    b_nxt      = b_r;
    e_nxt      = e_r;
    rr_nxt     = rr_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    pa_nxt     = pa_r;
    ps_nxt     = ps_r;
    bit_nxt    = bit_r;
    exp_nxt    = exp_r;
    err_nxt    = err_r;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          m_nxt   = q_data.modulus[W-1:0];
          b_nxt   = q_data.base_value[W-1:0];
          e_nxt   = q_data.exponent[W-1:0];
          err_nxt = q_data.zero_mod;
          rr_nxt  = '0;
          acc_nxt = '0;
          bit_nxt = LAST;
          state_nxt = q_data.zero_mod ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_t >= {1'b0, m_r}) begin
          rr_nxt = W'(red_t - {1'b0, m_r});
        end else begin
          rr_nxt = red_t[W-1:0];
        end
        b_nxt = b_r << 1;
        if (bit_r == '0) begin
          sq_nxt    = rr_nxt;
          acc_nxt   = (m_r == ONE) ? '0 : ONE;
          pa_nxt    = '0;
          ps_nxt    = '0;
          bit_nxt   = LAST;
          exp_nxt   = LAST;
          state_nxt = ST_MUL;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_MUL: begin
        pa_nxt = pa_step;
        ps_nxt = ps_step;
        if (bit_r == '0) begin
          acc_nxt = e_r[0] ? pa_step : acc_r;
          sq_nxt  = ps_step;
          e_nxt   = e_r >> 1;
          pa_nxt  = '0;
          ps_nxt  = '0;
          bit_nxt = LAST;
          if (exp_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            exp_nxt = exp_r - 1'b1;
          end
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ovalid_nxt = out_load | (ovalid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    b_r   <= b_nxt;
    e_r   <= e_nxt;
    rr_r  <= rr_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    pa_r  <= pa_nxt;
    ps_r  <= ps_nxt;
    bit_r <= bit_nxt;
    exp_r <= exp_nxt;
    err_r <= err_nxt;
    if (out_load) begin
      ores_r <= err_r ? '0 : acc_r;
      oerr_r <= err_r;
    end
  end

  `MEXP_ASSERT_IMP(a_mul_reduced, state_r == ST_MUL, (acc_r < m_r) && (sq_r < m_r) && (pa_r < m_r) && (ps_r < m_r), "operand not reduced")
  `MEXP_ASSERT_IMP(a_rem_reduced, state_r == ST_REDUCE, rr_r < m_r, "remainder not reduced")
  `MEXP_ASSERT_IMP(a_err_zero, ovalid_r && oerr_r, ores_r == '0, "error result not zero")
  `MEXP_ASSERT_IMP(a_pop_idle, q_pop, (state_r == ST_IDLE) && !q_empty, "pop outside idle")

endmodule
